[rtl/r2bf_pkg.sv]
// ----------------------------------------------------------------------------
// r2bf_pkg
// Shared types, sizes and elaboration-time twiddle math for the scaled
// radix-2 butterfly stage.
// ----------------------------------------------------------------------------
package r2bf_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int FRAC_BITS       = SAMPLE_BITS - 1;
    localparam int FFT_POINTS_DEF  = 1024;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_SQRT2_Q60 = 64'h0B504F333F9DE648;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] a_real;
        logic signed [SAMPLE_BITS-1:0] a_imag;
        logic signed [SAMPLE_BITS-1:0] b_real;
        logic signed [SAMPLE_BITS-1:0] b_imag;
        logic                          frame_end;
    } pair_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sum_real;
        logic signed [SAMPLE_BITS-1:0] sum_imag;
        logic signed [SAMPLE_BITS-1:0] diff_real;
        logic signed [SAMPLE_BITS-1:0] diff_imag;
        logic                          frame_end_out;
    } result_t;

    // one queued job: the input pair plus the twiddle looked up for it
    typedef struct packed {
        pair_t                         item;
        logic signed [SAMPLE_BITS-1:0] tw_real;
        logic signed [SAMPLE_BITS-1:0] tw_imag;
    } work_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    // Q60 product, bits 123:60 of the full 128-bit result
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // shift-subtract divide, used only while building the rom
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // non-negative Q60 to Q1.F, round half up, clip at 2^F-1
    function automatic logic [63:0] q60_to_frac(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] top;
        r   = (v + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        top = (64'd1 << FRAC_BITS) - 64'd1;
        return (r > top) ? top : r;
    endfunction

    localparam logic [SAMPLE_BITS-1:0] SCALE = SAMPLE_BITS'(q60_to_frac(INV_SQRT2_Q60));

    // rom entry k: {cos, -sin} of 2*pi*k/n, each Q1.F
    function automatic logic [2*SAMPLE_BITS-1:0] twiddle_entry(input int n_points, input int k);
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] wr;
        logic [63:0] wi;
        logic        flip;
        int          n;
        q    = 64'(n_points);
        p    = 64'(2 * k);
        flip = 1'b0;
        if (4 * k > n_points)
        begin
            p    = q - p;
            flip = 1'b1;
        end
        rem  = p;
        frac = '0;
        for (n = 0; n < 60; n++)
        begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= q)
            begin
                rem     = rem - q;
                frac[0] = 1'b1;
            end
        end
        x    = mul_q60(PI_Q60, frac);
        x2   = mul_q60(x, x);
        term = x;
        s    = x;
        for (n = 1; n < 30 && term != 0; n++)
        begin
            term = div_u64(mul_q60(term, x2), 64'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1)
                s = s - term;
            else
                s = s + term;
        end
        term = 64'd1 << 60;
        c    = term;
        for (n = 1; n < 30 && term != 0; n++)
        begin
            term = div_u64(mul_q60(term, x2), 64'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1)
                c = c - term;
            else
                c = c + term;
        end
        if (s > (64'd1 << 62))
            s = '0;
        if (c > (64'd1 << 62))
            c = '0;
        wr = flip ? (64'd0 - q60_to_frac(c)) : q60_to_frac(c);
        wi = 64'd0 - q60_to_frac(s);
        return {wr[SAMPLE_BITS-1:0], wi[SAMPLE_BITS-1:0]};
    endfunction

endpackage

[rtl/r2bf_twiddle_rom.sv]
// ----------------------------------------------------------------------------
// r2bf_twiddle_rom
// Half-period twiddle table with a registered read port.
// ----------------------------------------------------------------------------
module r2bf_twiddle_rom #(
    parameter int FFT_POINTS = r2bf_pkg::FFT_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [$clog2(FFT_POINTS/2)-1:0]      addr,
    output logic [2*r2bf_pkg::SAMPLE_BITS-1:0]   data_reg
);

    localparam int HALF = FFT_POINTS / 2;
    localparam int SB   = r2bf_pkg::SAMPLE_BITS;

    logic [2*SB-1:0] rom_table [HALF];

    for (genvar k = 0; k < HALF; k++)
    begin : g_entry
        localparam logic [2*SB-1:0] ENTRY = r2bf_pkg::twiddle_entry(FFT_POINTS, k);
        assign rom_table[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= rom_table[addr];
    end

endmodule

[rtl/r2bf_front.sv]
// ----------------------------------------------------------------------------
// r2bf_front
// Takes input pairs, steps the twiddle counter and fetches the twiddle,
// then hands each job to the queue.
// ----------------------------------------------------------------------------
module r2bf_front #(
    parameter int FFT_POINTS = r2bf_pkg::FFT_POINTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_ready,
    input  r2bf_pkg::pair_t   pair,
    output logic              push,
    output r2bf_pkg::work_t   push_data,
    input  logic              queue_full
);

    localparam int HALF  = FFT_POINTS / 2;
    localparam int CNT_W = $clog2(HALF);
    localparam int SB    = r2bf_pkg::SAMPLE_BITS;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(HALF - 1);

    logic             accept;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             valid_reg;
    logic             valid_next;
    r2bf_pkg::pair_t  item_reg;
    logic [2*SB-1:0]  tw_reg;

    assign pair_ready = !valid_reg || !queue_full;
    assign accept     = pair_valid && pair_ready;
    assign push       = valid_reg && !queue_full;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (pair.frame_end || cnt_reg == LAST_IDX)
                cnt_next = '0;
            else
                cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        valid_next = accept ? 1'b1 : (push ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= pair;
    end

    // rom address is the counter before this transfer bumps it
    r2bf_twiddle_rom #(
        .FFT_POINTS(FFT_POINTS)
    ) u_rom (
        .clk      (clk),
        .en       (accept),
        .addr     (cnt_reg),
        .data_reg (tw_reg)
    );

    always_comb
    begin
        push_data.item    = item_reg;
        push_data.tw_real = tw_reg[2*SB-1:SB];
        push_data.tw_imag = tw_reg[SB-1:0];
    end

endmodule

[rtl/r2bf_queue.sv]
// ----------------------------------------------------------------------------
// r2bf_queue
// Small job queue between the front and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module r2bf_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  r2bf_pkg::work_t           push_data,
    input  logic                      pop,
    output r2bf_pkg::work_t           head,
    output r2bf_pkg::queue_status_t   status
);

    localparam int DEPTH = r2bf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = r2bf_pkg::QPTR_W;
    localparam int CNT_W = r2bf_pkg::QCNT_W;

    r2bf_pkg::work_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = CNT_W'(count_reg + 1'b1);
            2'b01:   count_next = CNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            if (pop)
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

[rtl/r2bf_back.sv]
// ----------------------------------------------------------------------------
// r2bf_back
// Five-stage butterfly datapath: twiddle multiply, round, add/subtract,
// 1/sqrt2 scale, round and saturate. The whole pipe holds on output stall.
// ----------------------------------------------------------------------------
module r2bf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  r2bf_pkg::work_t     head,
    input  logic                queue_empty,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output r2bf_pkg::result_t   result
);

    localparam int SB  = r2bf_pkg::SAMPLE_BITS;
    localparam int F   = r2bf_pkg::FRAC_BITS;
    localparam int PW  = 2 * SB;          // twiddle product
    localparam int BW  = PW + 1 - F;      // rounded b*w
    localparam int SW  = BW + 1;          // a +/- b*w
    localparam int PRW = SW + SB + 1;     // scaled sum
    localparam int RW  = PRW - F;         // rounded scaled sum

    localparam logic signed [PW:0]    RND_P  = {{(PW + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [PRW-1:0] RND_S  = {{(PRW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [RW-1:0]  SAT_HI = {{(RW - F){1'b0}}, {F{1'b1}}};
    localparam logic signed [RW-1:0]  SAT_LO = {{(RW - F){1'b1}}, {F{1'b0}}};
    localparam logic signed [SB:0]    SCALE_S = {1'b0, r2bf_pkg::SCALE};

    function automatic logic signed [SB-1:0] round_sat(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] t;
        logic signed [RW-1:0]  r;
        t = p + RND_S;
        r = t[PRW-1:F];
        if (r > SAT_HI)
            r = SAT_HI;
        else if (r < SAT_LO)
            r = SAT_LO;
        return r[SB-1:0];
    endfunction

    logic advance;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;

    // stage 1
    logic signed [PW-1:0] p_rr_reg;
    logic signed [PW-1:0] p_ii_reg;
    logic signed [PW-1:0] p_ri_reg;
    logic signed [PW-1:0] p_ir_reg;
    logic signed [SB-1:0] ar1_reg;
    logic signed [SB-1:0] ai1_reg;
    logic                 last1_reg;
    // stage 2
    logic signed [PW:0]   re_sum;
    logic signed [PW:0]   im_sum;
    logic signed [BW-1:0] bwr_reg;
    logic signed [BW-1:0] bwi_reg;
    logic signed [SB-1:0] ar2_reg;
    logic signed [SB-1:0] ai2_reg;
    logic                 last2_reg;
    // stage 3
    logic signed [SW-1:0] sr_reg;
    logic signed [SW-1:0] si_reg;
    logic signed [SW-1:0] dr_reg;
    logic signed [SW-1:0] di_reg;
    logic                 last3_reg;
    // stage 4
    logic signed [PRW-1:0] psr_reg;
    logic signed [PRW-1:0] psi_reg;
    logic signed [PRW-1:0] pdr_reg;
    logic signed [PRW-1:0] pdi_reg;
    logic                  last4_reg;
    // stage 5
    r2bf_pkg::result_t     result_reg;

    assign advance      = !v5_reg || result_ready;
    assign pop          = advance && !queue_empty;
    assign result_valid = v5_reg;
    assign result       = result_reg;

    assign re_sum = (PW + 1)'(p_rr_reg) - (PW + 1)'(p_ii_reg) + RND_P;
    assign im_sum = (PW + 1)'(p_ri_reg) + (PW + 1)'(p_ir_reg) + RND_P;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= !queue_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_rr_reg  <= head.item.b_real * head.tw_real;
            p_ii_reg  <= head.item.b_imag * head.tw_imag;
            p_ri_reg  <= head.item.b_real * head.tw_imag;
            p_ir_reg  <= head.item.b_imag * head.tw_real;
            ar1_reg   <= head.item.a_real;
            ai1_reg   <= head.item.a_imag;
            last1_reg <= head.item.frame_end;

            // floor after adding half an lsb
            bwr_reg   <= re_sum[PW:F];
            bwi_reg   <= im_sum[PW:F];
            ar2_reg   <= ar1_reg;
            ai2_reg   <= ai1_reg;
            last2_reg <= last1_reg;

            sr_reg    <= SW'(ar2_reg) + SW'(bwr_reg);
            si_reg    <= SW'(ai2_reg) + SW'(bwi_reg);
            dr_reg    <= SW'(ar2_reg) - SW'(bwr_reg);
            di_reg    <= SW'(ai2_reg) - SW'(bwi_reg);
            last3_reg <= last2_reg;

            psr_reg   <= sr_reg * SCALE_S;
            psi_reg   <= si_reg * SCALE_S;
            pdr_reg   <= dr_reg * SCALE_S;
            pdi_reg   <= di_reg * SCALE_S;
            last4_reg <= last3_reg;

            result_reg.sum_real      <= round_sat(psr_reg);
            result_reg.sum_imag      <= round_sat(psi_reg);
            result_reg.diff_real     <= round_sat(pdr_reg);
            result_reg.diff_imag     <= round_sat(pdi_reg);
            result_reg.frame_end_out <= last4_reg;
        end
    end

endmodule

[rtl/radix2_fft_butterfly_stage.sv]
// ----------------------------------------------------------------------------
// radix2_fft_butterfly_stage
// Scaled radix-2 DIT butterfly: for each pair (a, b) it returns
// (a + b*W)/sqrt2 and (a - b*W)/sqrt2 in saturated Q1.15, with W taken from
// a ROM of FFT_POINTS/2 twiddles addressed by a counter that wraps at the
// half period or after frame_end. One pair is taken per clock and one result
// leaves per clock while result_ready is high; each pair transfer travels
// through the twiddle ROM read register, the 4-entry job queue and the
// multiply/round/scale pipeline before its result appears. The ROM port and
// the pipelined multipliers each take one pair a cycle while the output does
// not stall, which sets the rate. When the output stalls the queue soaks up
// the jobs in flight before pair_ready falls.
// ----------------------------------------------------------------------------
module radix2_fft_butterfly_stage #(
    parameter int FFT_POINTS = r2bf_pkg::FFT_POINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pair_valid,
    output logic                pair_ready,
    input  r2bf_pkg::pair_t     pair,
    output logic                result_valid,
    input  logic                result_ready,
    output r2bf_pkg::result_t   result
);

    logic                      push;
    logic                      pop;
    r2bf_pkg::work_t           push_data;
    r2bf_pkg::work_t           head;
    r2bf_pkg::queue_status_t   q_status;

    r2bf_front #(
        .FFT_POINTS(FFT_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .push       (push),
        .push_data  (push_data),
        .queue_full (q_status.full)
    );

    r2bf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    r2bf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .queue_empty  (q_status.empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // no job written into a full queue
    a_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n) push |-> !q_status.full
    ) else $error("queue written while full");

    // no job read from an empty queue
    a_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty
    ) else $error("queue read while empty");

    // a write without a read grows the queue by exactly one job
    a_count_up: assert property (
        @(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (q_status.count == $past(q_status.count) + 1'b1)
    ) else $error("queue count out of step with writes");

endmodule
